[sv/prnms_pkg.sv]
// Shared types, constants and control structs for the point radius suppression block.
package prnms_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_KEPT_DEF   = 256;
  localparam int COORD_BITS_DEF = 20;

  // Fixed field widths of the transaction payloads.
  localparam int FIELD_COORD_W = 20;
  localparam int TOTAL_W       = 9;
  localparam int DIST_W        = 16;
  localparam int R2_W          = 2 * DIST_W;

  localparam logic [DIST_W-1:0] MIN_DIST_RESET = 16'd32;

  // One input point.
  typedef struct packed {
    logic [FIELD_COORD_W-1:0] y_coord;
    logic [FIELD_COORD_W-1:0] x_coord;
    logic                     frame_start;
  } pt_t;

  // One result.
  typedef struct packed {
    logic               keep;
    logic [TOTAL_W-1:0] kept_total;
    logic               list_overflow;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
    logic out_free;
  } ctrl_status_t;

endpackage

[sv/prnms_ctrl.sv]
// Controller state machine: accepts a point, sequences the scan and commits the result.
module prnms_ctrl
  import prnms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         pt_valid,
  output logic         pt_stall,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Command decode from the current state.
  always_comb begin
    pt_stall   = (state != ST_IDLE);
    cmd.load   = (state == ST_IDLE) && pt_valid;
    cmd.issue  = (state == ST_SCAN) && !status.scan_done;
    cmd.commit = (state == ST_DONE) && status.out_free;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pt_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/prnms_dp.sv]
// Datapath: kept-point memory, distance pipeline, counters and the result register.
module prnms_dp
  import prnms_pkg::*;
#(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pt_t               pt,
  input  logic              cfg_we,
  input  logic [DIST_W-1:0] cfg_data,
  input  ctrl_cmd_t         cmd,
  output ctrl_status_t      status,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res
);

  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = (SQ_W + 1 > R2_W + 1) ? SQ_W + 1 : R2_W + 1;

  logic [COORD_BITS-1:0] kept_y [MAX_KEPT];
  logic [COORD_BITS-1:0] kept_x [MAX_KEPT];

  logic [DIST_W-1:0]     min_dist;
  logic [R2_W-1:0]       r2;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] cur_x;
  logic [CNT_W-1:0]      kept_count;
  logic                  overflow_flag;
  logic [CNT_W-1:0]      idx;
  logic                  near;

  logic                  v1;
  logic                  v2;
  logic                  v3;
  logic [COORD_BITS-1:0] rd_y;
  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] dx;
  logic [SQ_W-1:0]       sq_y;
  logic [SQ_W-1:0]       sq_x;
  logic [SUM_W-1:0]      dist2;

  logic                  keep_now;
  logic                  room;
  logic [CNT_W-1:0]      count_next;
  logic                  overflow_next;

  // Status towards the controller.
  assign status.scan_done = (idx == kept_count);
  assign status.pipe_busy = v1 | v2 | v3;
  assign status.out_free  = !res_valid || !res_stall;

  // Radius register, to be written only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= MIN_DIST_RESET;
    end else if (cfg_we) begin
      min_dist <= cfg_data;
    end
  end

  // Latch the point and the squared radius at the start of a transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_y <= COORD_BITS'(pt.y_coord);
      cur_x <= COORD_BITS'(pt.x_coord);
      r2    <= min_dist * min_dist;
    end
  end

  // Scan index over the stored kept points.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if (cmd.issue) begin
      idx <= idx + CNT_W'(1);
    end
  end

  // Stage one: registered memory read.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_y <= kept_y[idx[IDX_W-1:0]];
      rd_x <= kept_x[idx[IDX_W-1:0]];
    end
  end

  // Memory write when a kept point is stored.
  always_ff @(posedge clk) begin
    if (cmd.commit && keep_now && room) begin
      kept_y[kept_count[IDX_W-1:0]] <= cur_y;
      kept_x[kept_count[IDX_W-1:0]] <= cur_x;
    end
  end

  // Stages two and three: absolute differences, then squares.
  always_ff @(posedge clk) begin
    if (v1) begin
      dy <= (cur_y > rd_y) ? (cur_y - rd_y) : (rd_y - cur_y);
      dx <= (cur_x > rd_x) ? (cur_x - rd_x) : (rd_x - cur_x);
    end
    if (v2) begin
      sq_y <= dy * dy;
      sq_x <= dx * dx;
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Final compare: a stored point inside the radius suppresses this one.
  assign dist2 = SUM_W'(sq_y) + SUM_W'(sq_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      near <= 1'b0;
    end else if (cmd.load) begin
      near <= 1'b0;
    end else if (v3 && (dist2 < SUM_W'(r2))) begin
      near <= 1'b1;
    end
  end

  // Outcome of the transaction once the scan has drained.
  always_comb begin
    keep_now      = !near;
    room          = (kept_count < CNT_W'(MAX_KEPT));
    count_next    = kept_count;
    overflow_next = overflow_flag;
    if (keep_now) begin
      if (room) begin
        count_next = kept_count + CNT_W'(1);
      end else begin
        overflow_next = 1'b1;
      end
    end
  end

  // Kept count and sticky overflow; a frame start clears both.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (cmd.load && pt.frame_start) begin
      kept_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (cmd.commit) begin
      kept_count    <= count_next;
      overflow_flag <= overflow_next;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res.keep          <= keep_now;
      res.kept_total    <= TOTAL_W'(count_next);
      res.list_overflow <= overflow_next;
    end
  end

endmodule

[sv/point_radius_nms.sv]
// Top level of the greedy point non-maximum suppression block.
//
// Points arrive on the pt channel (pt_valid, pt_stall, pt) in priority order.
// Each point is compared with every kept point of the current frame, one
// stored point per cycle, and one result leaves on the res channel
// (res_valid, res_stall, res) giving keep, the stored count and the sticky
// overflow flag. A point with frame_start set empties the list first.
// The result is registered once the scan over the N kept points stored has
// passed the read, difference and square stages and the final compare; the
// one-per-cycle memory read of the scan sets how long this takes. The next
// point can be accepted once the result is registered, so every point pays
// for a scan of the whole kept list, which holds up to MAX_KEPT points.
// A new point is accepted once the previous one has left the controller,
// even while its result still waits in the output register.
// If the receiver stalls, the result holds and the next point waits in the
// final state until the output register is free.
// Synchronous reset empties the list, clears the overflow flag, drops any
// pending result and sets min_dist back to 32. The user must write the radius
// through cfg_we and cfg_data while the block is idle; the block does not enforce it.
module point_radius_nms
  import prnms_pkg::*;
#(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pt_valid,
  output logic              pt_stall,
  input  pt_t               pt,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res,
  input  logic              cfg_we,
  input  logic [DIST_W-1:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencing of each transaction.
  prnms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (pt_valid),
    .pt_stall (pt_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, distance pipeline and result register.
  prnms_dp #(
    .MAX_KEPT   (MAX_KEPT),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .pt        (pt),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

[sim/point_radius_nms_tb.sv]
// Self-checking testbench for the greedy point non-maximum suppression block.
`timescale 1ns / 100ps

module point_radius_nms_tb;
  import prnms_pkg::*;

  localparam int MAX_KEPT       = MAX_KEPT_DEF;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_DIRECTED     = 21;

  // One row of the directed table: an optional radius write, then a point.
  typedef struct packed {
    bit                set_radius;
    logic [DIST_W-1:0] radius;
    pt_t               p;
    bit                known;
    res_t              want;
  } stim_row_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              pt_valid  = 1'b0;
  logic              pt_stall;
  pt_t               pt        = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  res_t              res;
  logic              cfg_we    = 1'b0;
  logic [DIST_W-1:0] cfg_data  = '0;

  // Shadow copy of the kept list and the radius.
  logic [FIELD_COORD_W-1:0] list_y [MAX_KEPT];
  logic [FIELD_COORD_W-1:0] list_x [MAX_KEPT];
  int                       list_len = 0;
  logic                     list_ovf = 1'b0;
  logic [DIST_W-1:0]        radius_q = MIN_DIST_RESET;

  res_t pending_results [$];
  res_t want_res;
  int   fail_count   = 0;
  int   idle_pct     = 32;
  int   hold_ticket  = 0;
  int   hold_served  = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 16'd0, '{20'h00000, 20'h00000, 1'b1}, 1'b1, '{1'b1, 9'd1, 1'b0}},
    '{1'b0, 16'd0, '{20'h00000, 20'h00000, 1'b0}, 1'b1, '{1'b0, 9'd1, 1'b0}},
    '{1'b0, 16'd0, '{20'hFFFFF, 20'hFFFFF, 1'b0}, 1'b1, '{1'b1, 9'd2, 1'b0}},
    '{1'b0, 16'd0, '{20'h00000, 20'h0001F, 1'b0}, 1'b1, '{1'b0, 9'd2, 1'b0}},
    '{1'b0, 16'd0, '{20'h00000, 20'h00020, 1'b0}, 1'b1, '{1'b1, 9'd3, 1'b0}},
    '{1'b0, 16'd0, '{20'h0001F, 20'h00000, 1'b0}, 1'b1, '{1'b0, 9'd3, 1'b0}},
    '{1'b0, 16'd0, '{20'hFFFE9, 20'hFFFE9, 1'b0}, 1'b1, '{1'b0, 9'd3, 1'b0}},
    '{1'b0, 16'd0, '{20'hFFFE8, 20'hFFFE8, 1'b0}, 1'b1, '{1'b1, 9'd4, 1'b0}},
    '{1'b0, 16'd0, '{20'hAAAAA, 20'h55555, 1'b0}, 1'b0, '0},
    '{1'b0, 16'd0, '{20'h55555, 20'hAAAAA, 1'b0}, 1'b0, '0},
    '{1'b0, 16'd0, '{20'h00000, 20'h00000, 1'b1}, 1'b1, '{1'b1, 9'd1, 1'b0}},
    '{1'b1, 16'd0, '{20'h00005, 20'h00005, 1'b1}, 1'b1, '{1'b1, 9'd1, 1'b0}},
    '{1'b0, 16'd0, '{20'h00005, 20'h00005, 1'b0}, 1'b1, '{1'b1, 9'd2, 1'b0}},
    '{1'b1, 16'hFFFF, '{20'h00000, 20'h00000, 1'b1}, 1'b1, '{1'b1, 9'd1, 1'b0}},
    '{1'b0, 16'd0, '{20'hFFFFF, 20'h00000, 1'b0}, 1'b1, '{1'b1, 9'd2, 1'b0}},
    '{1'b0, 16'd0, '{20'h0FFFE, 20'h00000, 1'b0}, 1'b1, '{1'b0, 9'd2, 1'b0}},
    '{1'b0, 16'd0, '{20'h00000, 20'h0FFFF, 1'b0}, 1'b1, '{1'b1, 9'd3, 1'b0}},
    '{1'b0, 16'd0, '{20'h07FFF, 20'h07FFF, 1'b0}, 1'b0, '0},
    '{1'b1, 16'd1, '{20'h03039, 20'h01A85, 1'b1}, 1'b1, '{1'b1, 9'd1, 1'b0}},
    '{1'b0, 16'd0, '{20'h03039, 20'h01A86, 1'b0}, 1'b1, '{1'b1, 9'd2, 1'b0}},
    '{1'b0, 16'd0, '{20'h03039, 20'h01A86, 1'b0}, 1'b1, '{1'b0, 9'd2, 1'b0}}
  };

  point_radius_nms uut (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt        (pt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Judges one point against the shadow list and updates it, exactly as the
  // block should: strict comparison, each axis tested on its own first.
  function automatic res_t judge_point(input pt_t p);
    logic [63:0] dy, dx, r2;
    bit          near;
    res_t        r;
    int          i;
    r2 = {48'd0, radius_q} * {48'd0, radius_q};
    if (p.frame_start) begin
      list_len = 0;
      list_ovf = 1'b0;
    end
    near = 1'b0;
    for (i = 0; i < list_len && !near; i++) begin
      dy = (p.y_coord > list_y[i]) ? 64'(p.y_coord - list_y[i]) : 64'(list_y[i] - p.y_coord);
      dx = (p.x_coord > list_x[i]) ? 64'(p.x_coord - list_x[i]) : 64'(list_x[i] - p.x_coord);
      if (dy * dy < r2 && dx * dx < r2 && dy * dy + dx * dx < r2) begin
        near = 1'b1;
      end
    end
    if (!near) begin
      if (list_len < MAX_KEPT) begin
        list_y[list_len] = p.y_coord;
        list_x[list_len] = p.x_coord;
        list_len++;
      end else begin
        list_ovf = 1'b1;
      end
    end
    r.keep          = !near;
    r.kept_total    = TOTAL_W'(list_len);
    r.list_overflow = list_ovf;
    return r;
  endfunction

  // A coordinate within a window above a base point, saturated at the top.
  function automatic logic [FIELD_COORD_W-1:0] spread_coord(
    input logic [FIELD_COORD_W-1:0] base, input int unsigned width);
    int unsigned s;
    s = base + $urandom_range(0, width);
    return (s > 32'hFFFFF) ? 20'hFFFFF : s[FIELD_COORD_W-1:0];
  endfunction

  // Offers one point, with random idle cycles first, and records its expected
  // result once the transaction is accepted. Called and left at a falling edge.
  task automatic send_point(input pt_t p, input bit known, input res_t want);
    res_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      pt_valid <= 1'b0;
      @(negedge clk);
    end
    pt_valid <= 1'b1;
    pt       <= p;
    do @(posedge clk); while (pt_stall);
    predicted = judge_point(p);
    pending_results.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  // Stops offering points and waits until every expected result has arrived.
  task automatic wait_drain();
    pt_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes the radius register; only called with the block idle.
  task automatic write_radius(input logic [DIST_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    radius_q  = value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Random frames: mostly clusters around a base point so that suppression
  // is frequent, some scattered frames, repeated points, stray frame starts,
  // and two long frames that overrun the list.
  task automatic run_random_part();
    int          phase, frames, fsize, spread, f, k, sent;
    bit          big, clustered;
    logic [19:0] base_y, base_x;
    logic [15:0] r;
    pt_t         p;
    pt_t         seen [$];
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 6)
        0:       r = 16'd0;
        1:       r = 16'($urandom_range(1, 64));
        2:       r = 16'hFFFF;
        3:       r = 16'($urandom_range(0, 16'hFFFF));
        4:       r = 16'd1;
        default: r = 16'($urandom_range(16, 400));
      endcase
      wait_drain();
      write_radius(r);
      idle_pct = (phase == 4) ? 0 : 32;
      frames   = $urandom_range(3, 8);
      for (f = 0; f < frames; f++) begin
        big       = (f == 0) && (phase == 1 || phase == 7);
        fsize     = big ? 300 : $urandom_range(1, 24);
        clustered = !big && ($urandom_range(0, 99) < 65);
        spread    = 3 * r + 8;
        base_y    = 20'($urandom_range(0, 20'hFFFFF));
        base_x    = 20'($urandom_range(0, 20'hFFFFF));
        // Hold the result side off while points keep coming.
        if (phase == 3 && f == 0) hold_ticket++;
        seen.delete();
        for (k = 0; k < fsize; k++) begin
          if (seen.size() > 0 && $urandom_range(0, 99) < 10) begin
            p = seen[$urandom_range(0, seen.size() - 1)];
          end else if (clustered) begin
            p.y_coord = spread_coord(base_y, spread);
            p.x_coord = spread_coord(base_x, spread);
          end else begin
            p.y_coord = 20'($urandom_range(0, 20'hFFFFF));
            p.x_coord = 20'($urandom_range(0, 20'hFFFFF));
          end
          if (k == 0) begin
            p.frame_start = big || ($urandom_range(0, 99) >= 5);
          end else begin
            p.frame_start = !big && ($urandom_range(0, 99) < 3);
          end
          send_point(p, 1'b0, '0);
          seen.push_back(p);
          sent++;
        end
      end
      phase++;
    end
  endtask

  // Result side: random stalls, a long hold-off on request, and none at all
  // while idling is switched off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      res_stall   <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual keep=%0d total=%0d ovf=%0d",
                 $time, res.keep, res.kept_total, res.list_overflow);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("keep", want_res.keep, res.keep);
        check_field("kept_total", want_res.kept_total, res.kept_total);
        check_field("list_overflow", want_res.list_overflow, res.list_overflow);
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((pt_valid && !pt_stall) || (res_valid && !res_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random frames, drain and verdict.
  initial begin
    int row;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    for (row = 0; row < N_DIRECTED; row++) begin
      if (directed_rows[row].set_radius) begin
        wait_drain();
        write_radius(directed_rows[row].radius);
      end
      send_point(directed_rows[row].p, directed_rows[row].known, directed_rows[row].want);
    end
    run_random_part();
    wait_drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
